// File: design/grouped_pcm_radix_unpacker_macros.svh
// Assertion helpers for the unpacker.
`ifndef GROUPED_PCM_RADIX_UNPACKER_MACROS_SVH
`define GROUPED_PCM_RADIX_UNPACKER_MACROS_SVH

`ifndef SYNTHESIS
`define GPRU_ASSERT_IMPL(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("gpru: same-cycle check failed");
`define GPRU_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("gpru: next-cycle check failed");
`else
`define GPRU_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define GPRU_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: design/gpru_pkg.sv
package gpru_pkg;

  localparam int ACC_W   = 35;
  localparam int CNT_W   = 6;
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [5:0] STEP_MIN = 6'd2;
  localparam logic [5:0] STEP_MAX = 6'd51;

  typedef enum logic [2:0] {
    REG_LEVEL  = 3'd0,
    REG_STEP   = 3'd1,
    REG_OFFSET = 3'd2,
    REG_TOTAL  = 3'd3,
    REG_PAIR   = 3'd4
  } gpru_reg_t;

  typedef struct packed {
    logic [5:0] level_count;
    logic [5:0] step_count;
    logic [4:0] value_offset;
    logic [5:0] value_total;
    logic       pair_mode;
  } gpru_cfg_t;

  typedef struct packed {
    logic             start;
    logic [ACC_W-1:0] dividend;
    logic [5:0]       divisor;
  } gpru_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ACC_W-1:0] quotient;
    logic [5:0]       remainder;
  } gpru_div_res_t;

  function automatic logic [2:0] max_group_for(input logic [5:0] levels);
    logic [2:0] g;
    case (levels)
      6'd3:  g = 3'd5;
      6'd7:  g = 3'd6;
      6'd11: g = 3'd2;
      6'd13: g = 3'd4;
      6'd19: g = 3'd4;
      6'd25: g = 3'd3;
      6'd51: g = 3'd4;
      6'd4, 6'd8, 6'd15, 6'd16, 6'd26, 6'd31: g = 3'd1;
      default: g = 3'd0;
    endcase
    return g;
  endfunction

endpackage

// File: design/gpru_if.sv
interface gpru_in_if;
  logic valid;
  logic ready;
  logic stream_bit;

  modport source (output valid, output stream_bit, input ready);
  modport sink   (input valid, input stream_bit, output ready);
endinterface

interface gpru_out_if;
  logic              valid;
  logic              ready;
  logic signed [6:0] value;
  logic              channel;
  logic [5:0]        band;
  logic              group_last;
  logic              frame_last;

  modport source (output valid, output value, output channel, output band,
                  output group_last, output frame_last, input ready);
  modport sink   (input valid, input value, input channel, input band,
                  input group_last, input frame_last, output ready);
endinterface

// File: design/gpru_cfg.sv
module gpru_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [gpru_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [gpru_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [gpru_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                         cfg_pready,
  output gpru_pkg::gpru_cfg_t          cfg
);
  import gpru_pkg::*;

  gpru_cfg_t  cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx        = cfg_paddr[PADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_count  <= 6'd3;
      cfg_r.step_count   <= 6'd3;
      cfg_r.value_offset <= 5'd0;
      cfg_r.value_total  <= 6'd1;
      cfg_r.pair_mode    <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        REG_LEVEL:  cfg_r.level_count  <= cfg_pwdata[5:0];
        REG_STEP:   cfg_r.step_count   <= cfg_pwdata[5:0];
        REG_OFFSET: cfg_r.value_offset <= cfg_pwdata[4:0];
        REG_TOTAL:  cfg_r.value_total  <= cfg_pwdata[5:0];
        REG_PAIR:   cfg_r.pair_mode    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LEVEL:  cfg_prdata = {26'd0, cfg_r.level_count};
      REG_STEP:   cfg_prdata = {26'd0, cfg_r.step_count};
      REG_OFFSET: cfg_prdata = {27'd0, cfg_r.value_offset};
      REG_TOTAL:  cfg_prdata = {26'd0, cfg_r.value_total};
      REG_PAIR:   cfg_prdata = {31'd0, cfg_r.pair_mode};
      default:    cfg_prdata = '0;
    endcase
  end

endmodule

// File: design/gpru_divider.sv
module gpru_divider (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gpru_pkg::gpru_div_req_t req,
  output gpru_pkg::gpru_div_res_t res
);
  import gpru_pkg::*;

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [ACC_W-1:0] quo_r;
  logic [5:0]       rem_r;
  logic [5:0]       div_r;
  logic [6:0]       trial;
  logic             take;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_r, quo_r[ACC_W-1]};
  assign take  = trial >= {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(ACC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      div_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[ACC_W-2:0], take};
      rem_r <= take ? 6'(trial - {1'b0, div_r}) : trial[5:0];
    end
  end

  assign res.busy      = busy_r;
  assign res.done      = done_r;
  assign res.quotient  = quo_r;
  assign res.remainder = rem_r;

endmodule

// File: design/grouped_pcm_radix_unpacker.sv
// Grouped PCM radix unpacker.
// in_if carries one stream bit per beat, MSB first; out_if carries one
// decoded value per beat with its channel, band and group/frame flags.
// Registers are written over the cfg_ APB port (level_count, step_count,
// value_offset, value_total, pair_mode at 0x0..0x10); the user must write
// them only while idle, as the block itself does not enforce this.
// A bit that does not finish a group holds in_if.ready low through the
// power loop (one multiply per group value, g = group length) and a compare.
// The bit that finishes a group then adds g digit steps; each digit runs
// the shared restoring divider and hands the digit to the output register.
// The first value is valid in the output register once the final bit has
// passed the power loop, the compare, the divider and the emit state.
// When out_if.ready is low the finished value waits in the output
// register and the sequencer holds before the next digit; nothing is lost.
// Bits under an unsupported level, step count or empty frame are dropped.
// Reset (rst_n low at a clock edge) clears the partial word, bit count and
// frame position and returns the registers to their defaults.
`include "grouped_pcm_radix_unpacker_macros.svh"

module grouped_pcm_radix_unpacker #(
  parameter int MAX_VALUES = 56
) (
  input  logic                         clk,
  input  logic                         rst_n,
  gpru_in_if.sink                      in_if,
  gpru_out_if.source                   out_if,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [gpru_pkg::PADDR_W-1:0] cfg_paddr,
  input  logic [gpru_pkg::PDATA_W-1:0] cfg_pwdata,
  output logic [gpru_pkg::PDATA_W-1:0] cfg_prdata,
  output logic                         cfg_pready
);
  import gpru_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_POW   = 5'b00010,
    ST_CHECK = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_t;

  gpru_cfg_t     cfg;
  gpru_div_req_t div_req;
  gpru_div_res_t div_res;

  state_t           state_r;
  logic [ACC_W-1:0] word_acc_r;
  logic [5:0]       bits_taken_r;
  logic [5:0]       frame_pos_r;
  logic [ACC_W-1:0] pow_r;
  logic [2:0]       g_r;
  logic [2:0]       j_r;
  logic             ends_r;

  logic              out_valid_r;
  logic signed [6:0] out_value_r;
  logic              out_channel_r;
  logic [5:0]        out_band_r;
  logic              out_glast_r;
  logic              out_flast_r;

  logic       accept;
  logic       cfg_ok;
  logic [2:0] maxg;
  logic [6:0] total;
  logic [5:0] fp_adj;
  logic [6:0] room;
  logic [2:0] g_new;
  logic [40:0] prod;
  logic       complete;
  logic       out_free;
  logic       out_load;
  logic       last_digit;
  logic [5:0] idx;

  gpru_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  gpru_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .res   (div_res)
  );

  assign in_if.ready = (state_r == ST_IDLE);
  assign accept      = in_if.valid && in_if.ready;

  assign maxg   = max_group_for(cfg.level_count);
  assign cfg_ok = (maxg != 3'd0) && (cfg.step_count >= STEP_MIN) &&
                  (cfg.step_count <= STEP_MAX) && (cfg.value_total != 6'd0);
  assign total  = ({1'b0, cfg.value_total} > 7'(MAX_VALUES)) ? 7'(MAX_VALUES)
                                                             : {1'b0, cfg.value_total};
  assign fp_adj = ({1'b0, frame_pos_r} >= total) ? 6'd0 : frame_pos_r;
  assign room   = total - {1'b0, fp_adj};
  assign g_new  = (room < {4'd0, maxg}) ? room[2:0] : maxg;

  assign prod = {6'd0, pow_r} * {35'd0, cfg.step_count};

  // 2^bits_taken >= steps^g; the power never reaches 2^35
  assign complete = (bits_taken_r >= 6'(ACC_W)) ||
                    ((ACC_W'(1) << bits_taken_r) >= pow_r);

  assign out_free   = !out_valid_r || out_if.ready;
  assign out_load   = (state_r == ST_EMIT) && out_free;
  assign last_digit = (j_r == g_r - 3'd1);
  assign idx        = frame_pos_r + 6'(g_r) - 6'd1 - 6'(j_r);

  assign div_req.start    = ((state_r == ST_CHECK) && complete) ||
                            (out_load && !last_digit);
  assign div_req.dividend = (state_r == ST_CHECK) ? word_acc_r : div_res.quotient;
  assign div_req.divisor  = cfg.step_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      word_acc_r   <= '0;
      bits_taken_r <= '0;
      frame_pos_r  <= '0;
      j_r          <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept && cfg_ok) begin
            frame_pos_r  <= fp_adj;
            word_acc_r   <= {word_acc_r[ACC_W-2:0], in_if.stream_bit};
            bits_taken_r <= bits_taken_r + 6'd1;
            j_r          <= '0;
            state_r      <= ST_POW;
          end
        end
        ST_POW: begin
          if (last_digit) begin
            j_r     <= '0;
            state_r <= ST_CHECK;
          end else begin
            j_r <= j_r + 3'd1;
          end
        end
        ST_CHECK: begin
          state_r <= complete ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          if (div_res.done) begin
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (last_digit) begin
              word_acc_r   <= '0;
              bits_taken_r <= '0;
              frame_pos_r  <= ends_r ? 6'd0 : frame_pos_r + 6'(g_r);
              j_r          <= '0;
              state_r      <= ST_IDLE;
            end else begin
              j_r     <= j_r + 3'd1;
              state_r <= ST_DIV;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && cfg_ok) begin
      g_r    <= g_new;
      ends_r <= ({1'b0, fp_adj} + {4'd0, g_new}) >= total;
      pow_r  <= ACC_W'(1);
    end else if (state_r == ST_POW) begin
      pow_r <= prod[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_value_r   <= 7'({1'b0, div_res.remainder}) - 7'({2'b00, cfg.value_offset});
      out_channel_r <= cfg.pair_mode ? idx[0] : 1'b0;
      out_band_r    <= cfg.pair_mode ? {1'b0, idx[5:1]} : idx;
      out_glast_r   <= last_digit;
      out_flast_r   <= ends_r;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.value      = out_value_r;
  assign out_if.channel    = out_channel_r;
  assign out_if.band       = out_band_r;
  assign out_if.group_last = out_glast_r;
  assign out_if.frame_last = out_flast_r;

  `GPRU_ASSERT_IMPL(a_done_in_div, clk, rst_n, div_res.done, state_r == ST_DIV)
  `GPRU_ASSERT_IMPL(a_digit_in_range, clk, rst_n, state_r == ST_EMIT, j_r < g_r)
  `GPRU_ASSERT_IMPL(a_no_overwrite, clk, rst_n, out_load, !out_valid_r || out_if.ready)
  `GPRU_ASSERT_NEXT(a_start_busy, clk, rst_n, div_req.start, div_res.busy)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gpru_pkg::*;

  localparam int FRAME_CAP = 56;
  localparam int N_ROWS    = 47;

  typedef struct packed {
    logic signed [6:0] value;
    logic              channel;
    logic [5:0]        band;
    logic              group_last;
    logic              frame_last;
  } beat_t;

  typedef struct {
    bit          is_cfg;
    gpru_reg_t   addr;
    logic [31:0] data;
    logic        b;
    bit          typed;
    bit          has_beat;
    beat_t       beat;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_psel;
  logic               cfg_penable;
  logic               cfg_pwrite;
  logic [PADDR_W-1:0] cfg_paddr;
  logic [PDATA_W-1:0] cfg_pwdata;
  logic [PDATA_W-1:0] cfg_prdata;
  logic               cfg_pready;

  gpru_in_if  in_if();
  gpru_out_if out_if();

  grouped_pcm_radix_unpacker uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  gpru_cfg_t   cfg_now;
  logic [34:0] acc_word;
  logic [5:0]  acc_bits;
  logic [5:0]  frame_pos;
  beat_t       due_values[$];
  int          errors;
  int          bits_sent;
  int          bits_live;
  int          values_seen;
  int          cfg_writes;
  bit          calm;
  bit          hold_req;
  int          hold_left;
  int          levels_known[13] = '{3, 7, 11, 13, 19, 25, 51, 4, 8, 15, 16, 26, 31};
  row_t        script[N_ROWS];

  always #2 clk = ~clk;

  function automatic int group_limit(input logic [5:0] levels);
    case (levels)
      6'd3:  return 5;
      6'd7:  return 6;
      6'd11: return 2;
      6'd13, 6'd19, 6'd51: return 4;
      6'd25: return 3;
      6'd4, 6'd8, 6'd15, 6'd16, 6'd26, 6'd31: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic bit cfg_live();
    return group_limit(cfg_now.level_count) != 0 && cfg_now.step_count >= 6'd2 &&
           cfg_now.step_count <= 6'd51 && cfg_now.value_total != 6'd0;
  endfunction

  // Shifts one bit into the group word; on the final bit queues the digits.
  function automatic int decode_bit(input logic b);
    logic [63:0] span;
    logic [63:0] word;
    logic [63:0] steps;
    logic [63:0] digit;
    logic [5:0]  idx;
    int          total;
    int          g;
    int          nbits;
    bit          ends;
    beat_t       bt;
    if (!cfg_live())
      return 0;
    total = cfg_now.value_total;
    if (total > FRAME_CAP)
      total = FRAME_CAP;
    if (frame_pos >= total)
      frame_pos = '0;
    g = total - frame_pos;
    if (g > group_limit(cfg_now.level_count))
      g = group_limit(cfg_now.level_count);
    steps = cfg_now.step_count;
    span = 64'd1;
    repeat (g) span = span * steps;
    nbits = 0;
    while (nbits < 63 && (64'd1 << nbits) < span)
      nbits++;
    acc_word = {acc_word[33:0], b};
    acc_bits = acc_bits + 6'd1;
    if (acc_bits < nbits)
      return 0;
    word = {29'd0, acc_word};
    ends = (frame_pos + g) >= total;
    for (int j = 0; j < g; j++) begin
      idx = 6'(frame_pos + g - 1 - j);
      digit = word % steps;
      word = word / steps;
      bt.value = 7'(digit) - {2'b00, cfg_now.value_offset};
      bt.channel = cfg_now.pair_mode ? idx[0] : 1'b0;
      bt.band = cfg_now.pair_mode ? (idx >> 1) : idx;
      bt.group_last = (j == g - 1);
      bt.frame_last = ends;
      due_values.push_back(bt);
    end
    acc_word = '0;
    acc_bits = '0;
    frame_pos = ends ? 6'd0 : 6'(frame_pos + g);
    return g;
  endfunction

  task automatic cfg_write(input gpru_reg_t addr, input logic [31:0] data);
    logic [31:0] held;
    held = '0;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {addr, 2'b00};
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (addr)
      REG_LEVEL: begin
        cfg_now.level_count = data[5:0];
        held = {26'd0, data[5:0]};
      end
      REG_STEP: begin
        cfg_now.step_count = data[5:0];
        held = {26'd0, data[5:0]};
      end
      REG_OFFSET: begin
        cfg_now.value_offset = data[4:0];
        held = {27'd0, data[4:0]};
      end
      REG_TOTAL: begin
        cfg_now.value_total = data[5:0];
        held = {26'd0, data[5:0]};
      end
      REG_PAIR: begin
        cfg_now.pair_mode = data[0];
        held = {31'd0, data[0]};
      end
      default: held = '0;
    endcase
    cfg_writes++;
    // read back
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    if (cfg_prdata !== held) begin
      $error("register %s: expected %0d, got %0d", addr.name(), held, cfg_prdata);
      errors++;
    end
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_bit(input logic b, output int n);
    while (!calm && $urandom_range(99) < 8) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.stream_bit <= b;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    bits_sent++;
    if (cfg_live())
      bits_live++;
    n = decode_bit(b);
  endtask

  task automatic settle();
    in_if.valid <= 1'b0;
    while (due_values.size() != 0)
      @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin : receiver
    beat_t want;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        values_seen++;
        if (due_values.size() == 0) begin
          $error("unexpected beat: value %0d band %0d", out_if.value, out_if.band);
          errors++;
        end else begin
          want = due_values.pop_front();
          if (out_if.value !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, out_if.value);
            errors++;
          end
          if (out_if.channel !== want.channel) begin
            $error("channel: expected %0d, got %0d", want.channel, out_if.channel);
            errors++;
          end
          if (out_if.band !== want.band) begin
            $error("band: expected %0d, got %0d", want.band, out_if.band);
            errors++;
          end
          if (out_if.group_last !== want.group_last) begin
            $error("group_last: expected %0d, got %0d", want.group_last, out_if.group_last);
            errors++;
          end
          if (out_if.frame_last !== want.frame_last) begin
            $error("frame_last: expected %0d, got %0d", want.frame_last, out_if.frame_last);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_left = 600;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= calm || ($urandom_range(99) >= 8);
      end
    end
  end

  initial begin : stimulus
    int n;
    int nbits;
    logic [31:0] lvl;
    logic [31:0] stp;
    logic [31:0] off;
    logic [31:0] tot;
    logic [31:0] par;
    rst_n <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    in_if.valid <= 1'b0;
    in_if.stream_bit <= 1'b0;
    cfg_now = '{level_count: 6'd3, step_count: 6'd3, value_offset: 5'd0,
                value_total: 6'd1, pair_mode: 1'b0};
    acc_word = '0;
    acc_bits = '0;
    frame_pos = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    hold_left = 0;
    script = '{
      '{0, REG_LEVEL, 0, 1, 1, 0, '0},
      '{0, REG_LEVEL, 0, 0, 1, 1, '{7'sd2, 1'b0, 6'd0, 1'b1, 1'b1}},
      '{0, REG_LEVEL, 0, 1, 0, 0, '0},
      '{0, REG_LEVEL, 0, 1, 1, 1, '{7'sd0, 1'b0, 6'd0, 1'b1, 1'b1}},  // excess word
      '{1, REG_LEVEL, 7, 0, 0, 0, '0},
      '{1, REG_STEP, 2, 0, 0, 0, '0},
      '{1, REG_OFFSET, 25, 0, 0, 0, '0},
      '{1, REG_TOTAL, 56, 0, 0, 0, '0},
      '{1, REG_PAIR, 1, 0, 0, 0, '0},
      '{0, REG_LEVEL, 0, 1, 0, 0, '0},
      '{0, REG_LEVEL, 0, 1, 0, 0, '0},
      '{0, REG_LEVEL, 0, 1, 0, 0, '0},
      '{0, REG_LEVEL, 0, 1, 0, 0, '0},
      '{0, REG_LEVEL, 0, 1, 0, 0, '0},
      '{0, REG_LEVEL, 0, 1, 0, 0, '0},
      '{1, REG_TOTAL, 8, 0, 0, 0, '0},
      '{0, REG_LEVEL, 0, 0, 0, 0, '0},
      '{0, REG_LEVEL, 0, 0, 0, 0, '0},
      '{1, REG_LEVEL, 31, 0, 0, 0, '0},
      '{1, REG_STEP, 51, 0, 0, 0, '0},
      '{1, REG_OFFSET, 0, 0, 0, 0, '0},
      '{0, REG_LEVEL, 0, 1, 0, 0, '0},
      '{0, REG_LEVEL, 0, 1, 0, 0, '0},
      '{0, REG_LEVEL, 0, 0, 0, 0, '0},
      '{0, REG_LEVEL, 0, 0, 0, 0, '0},
      '{0, REG_LEVEL, 0, 1, 0, 0, '0},
      '{0, REG_LEVEL, 0, 0, 1, 1, '{7'sd50, 1'b0, 6'd0, 1'b1, 1'b0}},
      '{1, REG_LEVEL, 5, 0, 0, 0, '0},   // unsupported level
      '{0, REG_LEVEL, 0, 1, 1, 0, '0},
      '{1, REG_LEVEL, 31, 0, 0, 0, '0},
      '{1, REG_STEP, 1, 0, 0, 0, '0},
      '{0, REG_LEVEL, 0, 1, 1, 0, '0},
      '{1, REG_STEP, 52, 0, 0, 0, '0},
      '{0, REG_LEVEL, 0, 0, 1, 0, '0},
      '{1, REG_STEP, 2, 0, 0, 0, '0},
      '{1, REG_TOTAL, 0, 0, 0, 0, '0},   // empty frame
      '{0, REG_LEVEL, 0, 1, 1, 0, '0},
      '{1, REG_TOTAL, 63, 0, 0, 0, '0},  // clamps to 56
      '{1, REG_LEVEL, 7, 0, 0, 0, '0},
      '{1, REG_STEP, 51, 0, 0, 0, '0},
      '{0, REG_LEVEL, 0, 1, 0, 0, '0},
      '{0, REG_LEVEL, 0, 0, 0, 0, '0},
      '{0, REG_LEVEL, 0, 1, 0, 0, '0},
      '{1, REG_LEVEL, 4, 0, 0, 0, '0},   // word now already too long
      '{1, REG_STEP, 2, 0, 0, 0, '0},
      '{1, REG_TOTAL, 1, 0, 0, 0, '0},   // position past frame end
      '{0, REG_LEVEL, 0, 1, 1, 1, '{7'sd1, 1'b0, 6'd0, 1'b1, 1'b1}}
    };
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      if (script[i].is_cfg) begin
        settle();
        cfg_write(script[i].addr, script[i].data);
      end else begin
        send_bit(script[i].b, n);
        if (script[i].typed) begin
          repeat (n) void'(due_values.pop_back());
          if (script[i].has_beat)
            due_values.push_back(script[i].beat);
        end
      end
    end

    for (int phase = 0; bits_live < 290; phase++) begin
      settle();
      if (phase == 1) begin
        lvl = 11; stp = 2; off = 0; tot = 56; par = 0;
      end else if (phase == 3) begin
        lvl = 7; stp = 51; off = 31; tot = 56; par = 1;
      end else if (phase == 4) begin
        lvl = 3; stp = 2; off = 0; tot = 1; par = 0;
      end else begin
        lvl = ($urandom_range(99) < 85) ? levels_known[$urandom_range(12)] : $urandom_range(63);
        stp = ($urandom_range(99) < 85) ? $urandom_range(51, 2) : $urandom_range(63);
        off = $urandom_range(31);
        tot = ($urandom_range(99) < 85) ? $urandom_range(56, 1) : $urandom_range(63);
        par = $urandom_range(1);
      end
      cfg_write(REG_LEVEL, lvl);
      cfg_write(REG_STEP, stp);
      cfg_write(REG_OFFSET, off);
      cfg_write(REG_TOTAL, tot);
      cfg_write(REG_PAIR, par);
      calm = (phase == 2);
      if (!cfg_live())
        nbits = 3;
      else if (phase == 1)
        nbits = 40;
      else if (phase == 3)
        nbits = 72;
      else
        nbits = $urandom_range(60, 20);
      for (int k = 0; k < nbits; k++) begin
        if (phase == 1 && k == 0)
          hold_req = 1'b1;
        if (phase == 1 && k == 20) begin
          in_if.valid <= 1'b0;
          while (due_values.size() != 0)
            @(posedge clk);
        end
        send_bit($urandom_range(1), n);
      end
    end
    calm = 1'b0;

    in_if.valid <= 1'b0;
    while (due_values.size() != 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d stream bits (%0d under a decodable setting), %0d values checked",
             bits_sent, bits_live, values_seen);
    $display("%0d register writes read back; one long output hold, one drain pause",
             cfg_writes);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("testbench: errors");
    $finish;
  end

endmodule
